// File: rtl/biq_pkg.sv
// Shared types, constants and helper functions for the biquad filter.
package biq_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 28;
  localparam int COEF_W         = 32;
  localparam int NUM_COEFS      = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int STATE_BITS     = SAMPLE_BITS - 1 + COEF_FRAC_BITS + 7;
  localparam int PROD_W         = COEF_W + SAMPLE_BITS;
  localparam int EXT_W          = ((STATE_BITS > PROD_W) ? STATE_BITS : PROD_W) + 2;

  localparam logic [CFG_IDX_W-1:0] COEF_B0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] COEF_B1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] COEF_B2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] COEF_A1 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] COEF_A2 = CFG_IDX_W'(4);

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

  localparam logic signed [EXT_W-1:0] RND_HALF = EXT_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [EXT_W-1:0] Y_MAX    = (EXT_W'(1) << (SAMPLE_BITS - 1)) - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] Y_MIN    = -Y_MAX - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] ST_MAX   = (EXT_W'(1) << (STATE_BITS - 1)) - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] ST_MIN   = -ST_MAX - EXT_W'(1);

  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [STATE_BITS-1:0]  state_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [EXT_W-1:0]       ext_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Y,
    ST_B2,
    ST_A1,
    ST_A2,
    ST_FIN
  } biq_state_t;

  typedef enum logic [2:0] {
    SEL_B0,
    SEL_B1,
    SEL_B2,
    SEL_A1,
    SEL_A2
  } mul_sel_t;

  typedef struct packed {
    mul_sel_t sel;
    logic     mul_en;
    logic     accept;
    logic     do_y;
    logic     do_t1;
    logic     do_t2;
    logic     do_d1;
    logic     do_d2;
  } biq_ctl_t;

  function automatic state_t sat_state(input ext_t v);
    state_t r;
    if (v > ST_MAX) begin
      r = ST_MAX[STATE_BITS-1:0];
    end else if (v < ST_MIN) begin
      r = ST_MIN[STATE_BITS-1:0];
    end else begin
      r = v[STATE_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic over_state(input ext_t v);
    return (v > ST_MAX) || (v < ST_MIN);
  endfunction

endpackage

// File: rtl/biq_mul.sv
// Shared signed coefficient-by-sample multiplier with a registered product.
module biq_mul import biq_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  coef_t   a,
  input  sample_t b,
  output prod_t   p
);

  prod_t p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

// File: rtl/biq_ctrl.sv
// Sequencer that steps one sample through the shared multiplier.
module biq_ctrl import biq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     out_free,
  output logic     in_stall,
  output biq_ctl_t ctl
);

  biq_state_t state_r, state_nxt;
  logic       accept;

  assign in_stall = !((state_r == ST_IDLE) || ((state_r == ST_FIN) && out_free));
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_Y;
        end
      end
      ST_Y:  state_nxt = ST_B2;
      ST_B2: state_nxt = ST_A1;
      ST_A1: state_nxt = ST_A2;
      ST_A2: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = accept ? ST_Y : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.sel    = SEL_B0;
    ctl.mul_en = 1'b1;
    ctl.accept = accept;
    unique case (state_r)
      ST_IDLE: ctl.sel = SEL_B0;
      ST_Y: begin
        ctl.sel  = SEL_B1;
        ctl.do_y = 1'b1;
      end
      ST_B2: begin
        ctl.sel   = SEL_B2;
        ctl.do_t1 = 1'b1;
      end
      ST_A1: begin
        ctl.sel   = SEL_A1;
        ctl.do_t2 = 1'b1;
      end
      ST_A2: begin
        ctl.sel   = SEL_A2;
        ctl.do_d1 = 1'b1;
      end
      ST_FIN: begin
        ctl.sel    = SEL_B0;
        ctl.mul_en = out_free;
        ctl.do_d2  = out_free;
      end
      default: ctl.sel = SEL_B0;
    endcase
  end

endmodule

// File: rtl/biq_dp.sv
// Datapath holding the filter state, the partial sums and the output rounding.
module biq_dp import biq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  biq_ctl_t ctl,
  input  sample_t  in_sample,
  input  coef_t    coefs [NUM_COEFS],
  input  prod_t    prod,
  output coef_t    mul_a,
  output sample_t  mul_b,
  output sample_t  y,
  output logic     clip
);

  sample_t x_r;
  sample_t y_r;
  ext_t    t1_r;
  ext_t    t2_r;
  state_t  d1_r;
  state_t  d2_r;
  logic    clip_r;

  ext_t    acc;
  ext_t    rnd;
  ext_t    y_full;
  sample_t y_sat;
  logic    y_over;
  ext_t    d1_sum;
  ext_t    d2_sum;

  always_comb begin
    unique case (ctl.sel)
      SEL_B0: begin
        mul_a = coefs[COEF_B0];
        mul_b = in_sample;
      end
      SEL_B1: begin
        mul_a = coefs[COEF_B1];
        mul_b = x_r;
      end
      SEL_B2: begin
        mul_a = coefs[COEF_B2];
        mul_b = x_r;
      end
      SEL_A1: begin
        mul_a = coefs[COEF_A1];
        mul_b = y_r;
      end
      SEL_A2: begin
        mul_a = coefs[COEF_A2];
        mul_b = y_r;
      end
      default: begin
        mul_a = coefs[COEF_B0];
        mul_b = in_sample;
      end
    endcase
  end

  always_comb begin
    acc    = EXT_W'(prod) + EXT_W'(d1_r);
    rnd    = acc + RND_HALF;
    y_full = rnd >>> COEF_FRAC_BITS;
    y_over = (y_full > Y_MAX) || (y_full < Y_MIN);
    if (y_full > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_BITS-1:0];
    end else if (y_full < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_full[SAMPLE_BITS-1:0];
    end
    d1_sum = t1_r - EXT_W'(prod);
    d2_sum = t2_r - EXT_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      x_r <= in_sample;
    end
    if (ctl.do_y) begin
      y_r <= y_sat;
    end
    if (ctl.do_t1) begin
      t1_r <= EXT_W'(prod) + EXT_W'(d2_r);
    end
    if (ctl.do_t2) begin
      t2_r <= EXT_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r   <= '0;
      d2_r   <= '0;
      clip_r <= 1'b0;
    end else begin
      if (ctl.do_y) begin
        clip_r <= y_over;
      end
      if (ctl.do_d1) begin
        d1_r   <= sat_state(d1_sum);
        clip_r <= clip_r | over_state(d1_sum);
      end
      if (ctl.do_d2) begin
        d2_r <= sat_state(d2_sum);
      end
    end
  end

  assign y    = y_r;
  assign clip = clip_r | over_state(d2_sum);

endmodule

// File: rtl/biquad_iir_filter.sv
// Top level of the biquad filter in transposed direct form II.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid / in_stall  in_sample_in, in_last_in
//   out_      output     out_valid / out_stall out_sample_out, out_last_out, out_clipped
//   cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each sample makes five passes through the one shared multiplier, stepping the sequencer
// through ST_Y, ST_B2, ST_A1, ST_A2 and ST_FIN until its result enters the output register.
// A sample is accepted only when idle or in the last step with the output register free.
// A held output stall keeps the sequencer in its last step until the result register frees.
// Reset clears both delay registers and loads the default coefficients.
module biquad_iir_filter import biq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sample_t              in_sample_in,
  input  logic                 in_last_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sample_t              out_sample_out,
  output logic                 out_last_out,
  output logic                 out_clipped,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  coef_t    coefs_r [NUM_COEFS];
  biq_ctl_t ctl;
  logic     out_free;
  logic     last_r;
  logic     out_valid_r;
  sample_t  out_sample_r;
  logic     out_last_r;
  logic     out_clip_r;
  coef_t    mul_a;
  sample_t  mul_b;
  prod_t    prod;
  sample_t  y;
  logic     clip;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r[COEF_B0] <= COEF_ONE;
      coefs_r[COEF_B1] <= '0;
      coefs_r[COEF_B2] <= '0;
      coefs_r[COEF_A1] <= '0;
      coefs_r[COEF_A2] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        COEF_B0: coefs_r[COEF_B0] <= cfg_data;
        COEF_B1: coefs_r[COEF_B1] <= cfg_data;
        COEF_B2: coefs_r[COEF_B2] <= cfg_data;
        COEF_A1: coefs_r[COEF_A1] <= cfg_data;
        COEF_A2: coefs_r[COEF_A2] <= cfg_data;
        default: ;
      endcase
    end
  end

  biq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  biq_mul u_mul (
    .clk (clk),
    .en  (ctl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  biq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_sample (in_sample_in),
    .coefs     (coefs_r),
    .prod      (prod),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .y         (y),
    .clip      (clip)
  );

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      last_r <= in_last_in;
    end
    if (ctl.do_d2) begin
      out_sample_r <= y;
      out_last_r   <= last_r;
      out_clip_r   <= clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.do_d2) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_last_out   = out_last_r;
  assign out_clipped    = out_clip_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.accept |=> in_stall)
    else $error("Block accepted an item on the cycle after an accept.");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.do_d2 |=> out_valid)
    else $error("Finished item did not reach the output register.");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.do_y, ctl.do_t1, ctl.do_t2, ctl.do_d1, ctl.do_d2}))
    else $error("More than one datapath step active in a cycle.");

  a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.do_y |=> ctl.do_t1)
    else $error("Output rounding step was not followed by the first state sum.");

endmodule

// File: dv/biquad_checker.sv
// Checker for the biquad filter: predicts each filtered sample and compares the results.
`timescale 1ns / 1ps

module biquad_checker import biq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  sample_t              in_sample_in,
  input  logic                 in_last_in,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  sample_t              out_sample_out,
  input  logic                 out_last_out,
  input  logic                 out_clipped,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  output int                   errors,
  output int                   pending
);

  typedef struct packed {
    sample_t sample;
    logic    last;
    logic    clipped;
  } filt_out_t;

  localparam longint SMP_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SMP_MIN = -SMP_MAX - 1;
  localparam longint ST_TOP  = (longint'(1) <<< (STATE_BITS - 1)) - 1;
  localparam longint ST_BOT  = -ST_TOP - 1;
  localparam longint HALF_LSB = longint'(1) <<< (COEF_FRAC_BITS - 1);

  coef_t     coef [NUM_COEFS];
  state_t    z1;
  state_t    z2;
  filt_out_t filtered_q [$];
  int        err_cnt = 0;

  function automatic longint clamp(input longint v, input longint lo, input longint hi,
                                   inout logic hit);
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic filt_out_t filter_sample(input sample_t x, input logic last);
    filt_out_t r;
    longint    xs;
    longint    acc;
    longint    y;
    longint    t1;
    longint    t2;
    logic      hit;
    hit = 1'b0;
    xs  = longint'(x);
    acc = longint'(coef[COEF_B0]) * xs + longint'(z1);
    y   = clamp((acc + HALF_LSB) >>> COEF_FRAC_BITS, SMP_MIN, SMP_MAX, hit);
    t1  = clamp(longint'(coef[COEF_B1]) * xs + longint'(z2) - longint'(coef[COEF_A1]) * y,
                ST_BOT, ST_TOP, hit);
    t2  = clamp(longint'(coef[COEF_B2]) * xs - longint'(coef[COEF_A2]) * y,
                ST_BOT, ST_TOP, hit);
    z1 = state_t'(t1);
    z2 = state_t'(t2);
    r.sample  = sample_t'(y);
    r.last    = last;
    r.clipped = hit;
    return r;
  endfunction

  always @(posedge clk) begin
    filt_out_t want;
    if (!rst_n) begin
      coef[COEF_B0] = COEF_ONE;
      coef[COEF_B1] = '0;
      coef[COEF_B2] = '0;
      coef[COEF_A1] = '0;
      coef[COEF_A2] = '0;
      z1 = '0;
      z2 = '0;
      filtered_q.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NUM_COEFS) begin
        coef[cfg_index] = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected out item: sample_out %0d, last_out %0b, clipped %0b",
                 out_sample_out, out_last_out, out_clipped);
          err_cnt++;
        end else begin
          want = filtered_q.pop_front();
          if (out_sample_out !== want.sample) begin
            $error("sample_out: expected %0d, got %0d", want.sample, out_sample_out);
            err_cnt++;
          end
          if (out_last_out !== want.last) begin
            $error("last_out: expected %0b, got %0b", want.last, out_last_out);
            err_cnt++;
          end
          if (out_clipped !== want.clipped) begin
            $error("clipped: expected %0b, got %0b", want.clipped, out_clipped);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        filtered_q.push_back(filter_sample(in_sample_in, in_last_in));
      end
    end
    errors  <= err_cnt;
    pending <= filtered_q.size();
  end

endmodule

// File: dv/tb_biquad_iir_filter.sv
// Testbench top for the biquad filter: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_biquad_iir_filter;
  import biq_pkg::*;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCKS} stall_mode_t;
  typedef enum int {COEFS_RANDOM, COEFS_GENTLE, COEFS_EXTREME, COEFS_GAIN} coef_kind_t;

  localparam int          IDLE_LIMIT   = 2000;
  localparam int          END_WAIT     = 20;
  localparam int          RAND_PHASES  = 8;
  localparam int          PHASE_ITEMS  = 100;
  localparam int unsigned ONE_I        = 1 << COEF_FRAC_BITS;
  localparam coef_t       COEF_HALF    = COEF_ONE >>> 1;
  localparam coef_t       COEF_MAX     = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t       COEF_MIN     = {1'b1, {(COEF_W-1){1'b0}}};
  localparam sample_t     SMP_HI       = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t     SMP_LO       = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  sample_t              in_sample_in = '0;
  logic                 in_last_in = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  sample_t              out_sample_out;
  logic                 out_last_out;
  logic                 out_clipped;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;
  int                   chk_errors;
  int                   chk_pending;

  int          idle_cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_left = 0;
  int unsigned block_left = 0;
  logic        block_val = 1'b0;

  biquad_iir_filter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .in_last_in     (in_last_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_last_out   (out_last_out),
    .out_clipped    (out_clipped),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  biquad_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .in_last_in     (in_last_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_last_out   (out_last_out),
    .out_clipped    (out_clipped),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .errors         (chk_errors),
    .pending        (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_biquad_iir_filter: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    logic nxt;
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_BLOCKS));
      stall_left = $urandom_range(40, 300);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE: nxt = 1'b0;
      STALL_LIGHT: nxt = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: nxt = ($urandom_range(0, 3) != 0);
      default: begin
        if (block_left == 0) begin
          block_val  = ~block_val;
          block_left = $urandom_range(1, 12);
        end
        block_left--;
        nxt = block_val;
      end
    endcase
    out_stall <= nxt;
  end

  task automatic send_sample(input sample_t s, input logic last);
    in_valid     <= 1'b1;
    in_sample_in <= s;
    in_last_in   <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(input int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_coefs(input coef_t b0, input coef_t b1, input coef_t b2,
                            input coef_t a1, input coef_t a2, input logic add_stray);
    cfg_write(COEF_B0, b0);
    cfg_write(COEF_B1, b1);
    cfg_write(COEF_B2, b2);
    cfg_write(COEF_A1, a1);
    cfg_write(COEF_A2, a2);
    if (add_stray) begin
      cfg_write(CFG_IDX_W'($urandom_range(NUM_COEFS, (1 << CFG_IDX_W) - 1)), $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic coef_t draw_coef(input coef_kind_t kind, input int unsigned span);
    case (kind)
      COEFS_RANDOM: return coef_t'($urandom);
      COEFS_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return '0;
          default: return COEF_ONE;
        endcase
      end
      default: return coef_t'(int'($urandom_range(0, 2 * span)) - int'(span));
    endcase
  endfunction

  task automatic load_random_coefs(input coef_kind_t kind);
    case (kind)
      COEFS_GENTLE: begin
        load_coefs(draw_coef(kind, ONE_I), draw_coef(kind, ONE_I), draw_coef(kind, ONE_I),
                   draw_coef(kind, 2 * ONE_I), coef_t'($urandom_range(0, ONE_I - ONE_I / 16)),
                   1'b1);
      end
      COEFS_GAIN: begin
        load_coefs(draw_coef(kind, 4 * ONE_I), '0, '0, '0, '0, 1'b1);
      end
      default: begin
        load_coefs(draw_coef(kind, 0), draw_coef(kind, 0), draw_coef(kind, 0),
                   draw_coef(kind, 0), draw_coef(kind, 0), 1'b1);
      end
    endcase
  endtask

  function automatic sample_t draw_sample();
    case ($urandom_range(0, 9))
      0: return SMP_HI;
      1: return SMP_LO;
      2, 3: return sample_t'(int'($urandom_range(0, 128)) - 64);
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned burst;
    int unsigned left;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // With the default unity gain the output must equal the input.
    send_sample('0, 1'b0);
    send_sample(SMP_HI, 1'b0);
    send_sample(SMP_LO, 1'b0);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(-1), 1'b1);

    // A gain of one half puts every odd input exactly on a rounding tie.
    drain_results();
    load_coefs(COEF_HALF, '0, '0, '0, '0, 1'b1);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(3), 1'b0);
    send_sample(sample_t'(-3), 1'b1);

    drain_results();
    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b0);
    send_sample(SMP_HI, 1'b0);
    send_sample(SMP_LO, 1'b0);
    send_sample(SMP_HI, 1'b1);
    send_sample('0, 1'b0);

    drain_results();
    load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 1'b0);
    send_sample(SMP_LO, 1'b0);
    send_sample(SMP_HI, 1'b0);
    send_sample(SMP_LO, 1'b0);
    send_sample('0, 1'b1);

    // A low-pass section; the state must carry across the buffer end.
    drain_results();
    load_coefs(coef_t'(18119393), coef_t'(36238786), coef_t'(18119393),
               coef_t'(-306821726), coef_t'(110810156), 1'b0);
    send_sample(SMP_HI, 1'b0);
    send_sample(SMP_HI, 1'b1);
    send_sample(SMP_HI, 1'b0);
    send_sample(SMP_LO, 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample('0, 1'b0);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      load_random_coefs(coef_kind_t'(ph % 4));
      left  = PHASE_ITEMS;
      burst = 0;
      while (left > 0) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 24);
          pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
          if ($urandom_range(0, 39) == 0) begin
            drain_results();
          end
        end
        send_sample(draw_sample(), $urandom_range(0, 15) == 0);
        burst--;
        left--;
      end
    end

    drain_results();
    repeat (END_WAIT) @(posedge clk);
    if (chk_errors == 0) begin
      $display("tb_biquad_iir_filter: done, clean");
    end else begin
      $display("tb_biquad_iir_filter: done, errors");
    end
    $finish;
  end

endmodule

// File: biquad_iir_filter.f
rtl/biq_pkg.sv
rtl/biq_mul.sv
rtl/biq_ctrl.sv
rtl/biq_dp.sv
rtl/biquad_iir_filter.sv
dv/biquad_checker.sv
dv/tb_biquad_iir_filter.sv
